[hdl/i2cbs_pkg.sv]
`timescale 1ns / 1ps
// shared types, command codes and constants of the i2c master bit sequencer
package i2cbs_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int PHASE_W       = 5;
  localparam int TICK_W        = 16;
  localparam int CMD_W         = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd10;

  // register index within the configuration space
  localparam logic REG_PHASE_TICKS = 1'b0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_START     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEND_ACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEND_NACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAIT_ACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

  typedef struct packed {
    logic                     command_valid;
    logic [CMD_W-1:0]         command;
    logic [BITS_PER_BYTE-1:0] write_data;
    logic                     sda_sample;
  } tick_t;

  typedef struct packed {
    logic                     scl_release;
    logic                     sda_release;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] read_data;
    logic                     ack_seen;
  } result_t;

  // bus line levels, 1 means released
  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  function automatic logic [PHASE_W-1:0] phase_count(input logic [CMD_W-1:0] cmd);
    logic [PHASE_W-1:0] n;
    case (cmd)
      CMD_START, CMD_STOP:          n = PHASE_W'(2);
      CMD_SEND_ACK:                 n = PHASE_W'(5);
      CMD_SEND_NACK, CMD_WAIT_ACK:  n = PHASE_W'(3);
      CMD_WRITE:                    n = PHASE_W'(3 * BITS_PER_BYTE);
      default:                      n = PHASE_W'(2 * BITS_PER_BYTE);
    endcase
    return n;
  endfunction

endpackage

[hdl/i2cbs_phase.sv]
`timescale 1ns / 1ps
// line levels of one phase of a command sequence
module i2cbs_phase (
  input  logic [i2cbs_pkg::CMD_W-1:0]         cmd,
  input  logic [i2cbs_pkg::PHASE_W-1:0]       phase,
  input  logic [i2cbs_pkg::BITS_PER_BYTE-1:0] shift_byte,
  input  i2cbs_pkg::lines_t                   cur,
  output i2cbs_pkg::lines_t                   nxt
);
  import i2cbs_pkg::*;

  logic [8:0]           prod;
  logic [3:0]           bit_num;
  logic [PHASE_W-1:0]   rem;
  logic [1:0]           sub;
  logic [BIT_IDX_W-1:0] bitpos;

  // phase / 3 by reciprocal, exact for phase below 32
  always_comb begin
    prod    = 9'(phase) * 9'd11;
    bit_num = prod[8:5];
    rem     = phase - PHASE_W'({bit_num, 1'b0}) - PHASE_W'(bit_num);
    sub     = rem[1:0];
    bitpos  = BIT_IDX_W'(BITS_PER_BYTE - 1) - bit_num[BIT_IDX_W-1:0];
  end

  always_comb begin
    nxt = cur;
    case (cmd)
      CMD_START: begin
        nxt.scl = 1'b1;
        nxt.sda = (phase == '0);
      end
      CMD_STOP: begin
        nxt.scl = 1'b1;
        nxt.sda = (phase != '0);
      end
      CMD_SEND_ACK: begin
        case (phase)
          5'd0:    nxt = '{scl: 1'b0, sda: 1'b1};
          5'd1:    nxt = '{scl: 1'b0, sda: 1'b0};
          5'd2:    nxt = '{scl: 1'b1, sda: 1'b0};
          5'd3:    nxt = '{scl: 1'b0, sda: 1'b0};
          5'd4:    nxt = '{scl: 1'b0, sda: 1'b1};
          default: nxt = cur;
        endcase
      end
      CMD_SEND_NACK, CMD_WAIT_ACK: begin
        nxt.scl = (phase == 5'd1);
        nxt.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (sub == 2'd0) begin
          nxt.scl = 1'b0;
        end else begin
          nxt.scl = (sub == 2'd2);
          nxt.sda = shift_byte[bitpos];
        end
      end
      default: begin
        nxt.scl = phase[0];
        nxt.sda = 1'b1;
      end
    endcase
  end

endmodule

[hdl/i2cbs_cfg.sv]
`timescale 1ns / 1ps
// apb register file holding the phase length
module i2cbs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cbs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [i2cbs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [i2cbs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [i2cbs_pkg::TICK_W-1:0]        phase_ticks
);
  import i2cbs_pkg::*;

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready && (reg_index == REG_PHASE_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (wr_en) begin
      phase_ticks <= pwdata[TICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_PHASE_TICKS) begin
      prdata = CFG_DATA_W'(phase_ticks);
    end
  end

endmodule

[hdl/i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps
// top level of the i2c master bit sequencer
// One transaction on the tick channel is one clock tick of the i2c line sequencer and
// produces exactly one transaction on the result channel, carrying the scl/sda release
// levels, busy, a one-tick done pulse, the last read byte and the last ack status.
// The block takes one tick per clock cycle while the result side keeps up: a tick
// lands in an input register; once the output register is free or being emptied,
// the sequencer state (phase index, tick counter, shift byte, line levels) is
// stepped by short logic and the result lands in the output register.
// A command is started only while idle; commands offered while a sequence runs, on
// the tick of the done pulse, or with the unused code seven are dropped. Each phase
// is held for phase_ticks ticks (register 0 at byte address 0, zero acts as one).
module i2c_master_bit_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // tick channel
  input  logic                             tick_valid,
  output logic                             tick_ready,
  input  i2cbs_pkg::tick_t                 tick,
  // result channel
  output logic                             result_valid,
  input  logic                             result_ready,
  output i2cbs_pkg::result_t               result,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2cbs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2cbs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2cbs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import i2cbs_pkg::*;

  // configuration
  logic [TICK_W-1:0] phase_ticks;

  // input register stage
  logic  a_valid;
  tick_t a_item;
  logic  fire;

  // sequencer state
  logic [PHASE_W-1:0]       phase_index, phase_index_next;
  logic [TICK_W-1:0]        tick_count, tick_count_next;
  logic [CMD_W-1:0]         active_command, active_command_next;
  logic [BITS_PER_BYTE-1:0] shift_byte, shift_byte_next;
  lines_t                   lines, lines_next;
  logic                     ack_flag, ack_flag_next;
  logic                     running, running_next;
  logic [BITS_PER_BYTE-1:0] last_read, last_read_next;
  logic                     done_next;

  // phase lookup select
  logic [CMD_W-1:0]         cmd_sel;
  logic [PHASE_W-1:0]       phase_sel;
  logic [BITS_PER_BYTE-1:0] shift_sel;
  logic                     apply;
  lines_t                   phase_lines;
  logic [BITS_PER_BYTE-1:0] shift_upd;
  logic [PHASE_W-1:0]       phase_inc;

  result_t result_next;

  i2cbs_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .phase_ticks (phase_ticks)
  );

  i2cbs_phase u_phase (
    .cmd        (cmd_sel),
    .phase      (phase_sel),
    .shift_byte (shift_sel),
    .cur        (lines),
    .nxt        (phase_lines)
  );

  // a tick advances once the output register is free or being emptied
  assign fire       = a_valid && (!result_valid || result_ready);
  assign tick_ready = !a_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (tick_ready) begin
      a_valid <= tick_valid;
    end
    if (tick_ready && tick_valid) begin
      a_item <= tick;
    end
  end

  // one step of the sequencer
  always_comb begin
    phase_index_next    = phase_index;
    tick_count_next     = tick_count;
    active_command_next = active_command;
    shift_byte_next     = shift_byte;
    ack_flag_next       = ack_flag;
    running_next        = running;
    last_read_next      = last_read;
    done_next           = 1'b0;
    cmd_sel             = active_command;
    phase_sel           = '0;
    shift_sel           = shift_byte;
    apply               = 1'b0;
    phase_inc           = phase_index + PHASE_W'(1);
    shift_upd           = shift_byte;

    if (running) begin
      if (tick_count >= phase_ticks) begin
        // end of phase: sample sda on the scl-high phases that need it
        if (active_command == CMD_WAIT_ACK && phase_index == PHASE_W'(1)) begin
          ack_flag_next = a_item.sda_sample;
        end
        if (active_command == CMD_READ && phase_index[0]) begin
          shift_upd = {shift_byte[BITS_PER_BYTE-2:0], a_item.sda_sample};
        end
        shift_byte_next = shift_upd;
        tick_count_next = TICK_W'(1);
        if (phase_inc >= phase_count(active_command)) begin
          running_next     = 1'b0;
          done_next        = 1'b1;
          phase_index_next = '0;
          if (active_command == CMD_READ) begin
            last_read_next = shift_upd;
          end
        end else begin
          phase_index_next = phase_inc;
          apply            = 1'b1;
          phase_sel        = phase_inc;
          shift_sel        = shift_upd;
        end
      end else begin
        tick_count_next = tick_count + TICK_W'(1);
      end
    end else if (a_item.command_valid && a_item.command <= CMD_READ) begin
      // start a new command, first phase shows at once
      active_command_next = a_item.command;
      running_next        = 1'b1;
      phase_index_next    = '0;
      tick_count_next     = TICK_W'(1);
      shift_byte_next     = (a_item.command == CMD_WRITE) ? a_item.write_data : '0;
      cmd_sel             = a_item.command;
      shift_sel           = shift_byte_next;
      apply               = 1'b1;
    end

    lines_next = apply ? phase_lines : lines;

    result_next.scl_release = lines_next.scl;
    result_next.sda_release = lines_next.sda;
    result_next.busy_res    = running_next;
    result_next.done_res    = done_next;
    result_next.read_data   = last_read_next;
    result_next.ack_seen    = ack_flag_next;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      tick_count     <= '0;
      active_command <= CMD_START;
      shift_byte     <= '0;
      lines          <= '{scl: 1'b1, sda: 1'b1};
      ack_flag       <= 1'b0;
      running        <= 1'b0;
      last_read      <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (fire) begin
        phase_index    <= phase_index_next;
        tick_count     <= tick_count_next;
        active_command <= active_command_next;
        shift_byte     <= shift_byte_next;
        lines          <= lines_next;
        ack_flag       <= ack_flag_next;
        running        <= running_next;
        last_read      <= last_read_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (fire) begin
      result <= result_next;
    end
  end

  // a finished sequence leaves the sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    (fire && done_next) |=> !running)
    else $error("sequencer still running after done");

  // a running phase always has counted at least one tick
  assert property (@(posedge clk) disable iff (rst)
    running |-> (tick_count != '0))
    else $error("tick counter at zero while running");

  // phase index stays inside the command's list, and rests at zero when idle
  assert property (@(posedge clk) disable iff (rst)
    running ? (phase_index < phase_count(active_command)) : (phase_index == '0))
    else $error("phase index out of range");

endmodule

[test/i2c_master_bit_sequencer_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the i2c master bit sequencer with a line-level predictor
module i2c_master_bit_sequencer_test;
  import i2cbs_pkg::*;

  // code seven is not a command, the block must stay idle on it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] PHASE_TICKS_ADDR = CFG_ADDR_W'(4 * int'(REG_PHASE_TICKS));
  localparam int LONG_HOLD = 400;
  localparam int IDLE_MAX = 18;

  // predictor of the scl/sda line levels plus the queue of expected results
  class line_sequencer_sb;
    logic [TICK_W-1:0]        hold_ticks;
    logic [PHASE_W-1:0]       phase_idx;
    logic [TICK_W-1:0]        tick_cnt;
    logic [CMD_W-1:0]         active_cmd;
    logic [BITS_PER_BYTE-1:0] shift_reg;
    logic [BITS_PER_BYTE-1:0] read_byte;
    logic                     scl_lvl;
    logic                     sda_lvl;
    logic                     ack_lvl;
    logic                     busy;
    result_t                  expected_lines[$];
    int                       errors;
    int                       printed;
    int                       ticks_seen;
    int                       results_seen;
    int                       started[8];

    function new();
      hold_ticks = PHASE_TICKS_RESET;
      phase_idx = '0;
      tick_cnt = '0;
      active_cmd = CMD_START;
      shift_reg = '0;
      read_byte = '0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      ack_lvl = 1'b0;
      busy = 1'b0;
      errors = 0;
      printed = 0;
      ticks_seen = 0;
      results_seen = 0;
      foreach (started[i]) started[i] = 0;
    endfunction

    function void set_hold(logic [TICK_W-1:0] v);
      hold_ticks = v;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // number of phases in the list of one command
    function logic [PHASE_W-1:0] phases_of(logic [CMD_W-1:0] cmd);
      case (cmd)
        CMD_START, CMD_STOP:         return PHASE_W'(2);
        CMD_SEND_ACK:                return PHASE_W'(5);
        CMD_SEND_NACK, CMD_WAIT_ACK: return PHASE_W'(3);
        CMD_WRITE:                   return PHASE_W'(3 * BITS_PER_BYTE);
        default:                     return PHASE_W'(2 * BITS_PER_BYTE);
      endcase
    endfunction

    // line levels set on entry to phase p
    function void enter_phase(logic [CMD_W-1:0] cmd, logic [PHASE_W-1:0] p);
      int bit_pos;
      case (cmd)
        CMD_START: begin
          scl_lvl = 1'b1;
          sda_lvl = (p == 0);
        end
        CMD_STOP: begin
          scl_lvl = 1'b1;
          sda_lvl = (p != 0);
        end
        CMD_SEND_ACK: begin
          case (p)
            0: begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
            1: begin scl_lvl = 1'b0; sda_lvl = 1'b0; end
            2: begin scl_lvl = 1'b1; sda_lvl = 1'b0; end
            3: begin scl_lvl = 1'b0; sda_lvl = 1'b0; end
            4: begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
            default: ;
          endcase
        end
        CMD_SEND_NACK, CMD_WAIT_ACK: begin
          scl_lvl = (p == 1);
          sda_lvl = 1'b1;
        end
        CMD_WRITE: begin
          bit_pos = (BITS_PER_BYTE - 1) - (int'(p) / 3) % BITS_PER_BYTE;
          if (int'(p) % 3 == 0) begin
            scl_lvl = 1'b0;
          end else begin
            scl_lvl = (int'(p) % 3 == 2);
            sda_lvl = shift_reg[bit_pos];
          end
        end
        default: begin
          scl_lvl = p[0];
          sda_lvl = 1'b1;
        end
      endcase
    endfunction

    // one tick of the sequencer, returns the line state after it
    function result_t advance(tick_t t);
      result_t r;
      logic    fin;
      fin = 1'b0;
      if (busy) begin
        if (tick_cnt >= hold_ticks) begin
          if (active_cmd == CMD_WAIT_ACK && phase_idx == 1) ack_lvl = t.sda_sample;
          if (active_cmd == CMD_READ && phase_idx[0])
            shift_reg = {shift_reg[BITS_PER_BYTE-2:0], t.sda_sample};
          phase_idx = phase_idx + 1'b1;
          tick_cnt = 1;
          if (phase_idx >= phases_of(active_cmd)) begin
            busy = 1'b0;
            fin = 1'b1;
            phase_idx = '0;
            if (active_cmd == CMD_READ) read_byte = shift_reg;
          end else begin
            enter_phase(active_cmd, phase_idx);
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end else if (t.command_valid && t.command != CMD_UNUSED) begin
        active_cmd = t.command;
        busy = 1'b1;
        phase_idx = '0;
        tick_cnt = 1;
        shift_reg = (t.command == CMD_WRITE) ? t.write_data : '0;
        started[t.command]++;
        enter_phase(t.command, '0);
      end
      r = '0;
      r.scl_release = scl_lvl;
      r.sda_release = sda_lvl;
      r.busy_res = busy;
      r.done_res = fin;
      r.read_data = read_byte;
      r.ack_seen = ack_lvl;
      return r;
    endfunction

    function void note_tick(tick_t t);
      expected_lines.push_back(advance(t));
      ticks_seen++;
    endfunction

    task report(string msg);
      errors++;
      if (printed < 40) begin
        $display("[%0t] error: %s", $time, msg);
        printed++;
      end
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_lines.size() == 0) begin
        report($sformatf("result with nothing pending: %h", got));
      end else begin
        want = expected_lines.pop_front();
        results_seen++;
        if (got.scl_release !== want.scl_release)
          report($sformatf("result %0d scl_release %b want %b", results_seen,
                           got.scl_release, want.scl_release));
        if (got.sda_release !== want.sda_release)
          report($sformatf("result %0d sda_release %b want %b", results_seen,
                           got.sda_release, want.sda_release));
        if (got.busy_res !== want.busy_res)
          report($sformatf("result %0d busy_res %b want %b", results_seen,
                           got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report($sformatf("result %0d done_res %b want %b", results_seen,
                           got.done_res, want.done_res));
        if (got.read_data !== want.read_data)
          report($sformatf("result %0d read_data %h want %h", results_seen,
                           got.read_data, want.read_data));
        if (got.ack_seen !== want.ack_seen)
          report($sformatf("result %0d ack_seen %b want %b", results_seen,
                           got.ack_seen, want.ack_seen));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  tick_valid = 1'b0;
  logic                  tick_ready;
  tick_t                 tick = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  line_sequencer_sb sb = new();

  // idle limits of both sides, changed per phase of the run
  int send_gap_max = IDLE_MAX;
  int recv_gap_max = IDLE_MAX;
  // asks the result side for one long hold-off
  bit hold_req = 1'b0;

  i2c_master_bit_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(4_000_000);
    $display("i2c_master_bit_sequencer: mismatch");
    $finish;
  end

  // apb write: setup cycle, then access cycle until pready
  task cfg_write(logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PHASE_TICKS_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_hold(value[TICK_W-1:0]);
  endtask

  // apb read back of phase_ticks, compared with the predictor copy
  task cfg_read_check();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PHASE_TICKS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(sb.hold_ticks))
      sb.report($sformatf("phase_ticks read %h want %h", prdata, sb.hold_ticks));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one tick transaction after a random gap, return once it is taken
  task send_tick(tick_t t);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (!tick_ready);
    sb.note_tick(t);
  endtask

  // one command and the ticks until its sequence ends
  // sda_mode: 0 holds sda low, 1 high, 2 random
  // hammer offers a new command on every busy tick, done tick included
  task run_command(logic [CMD_W-1:0] cmd, logic [7:0] wdata, int sda_mode, bit hammer);
    tick_t t;
    t.command_valid = 1'b1;
    t.command = cmd;
    t.write_data = wdata;
    t.sda_sample = (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode);
    send_tick(t);
    while (sb.busy) begin
      t.command_valid = hammer;
      t.command = 3'($urandom);
      t.write_data = 8'($urandom);
      t.sda_sample = (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode);
      send_tick(t);
    end
  endtask

  // random ticks: mostly fresh commands when idle, mostly quiet ticks when busy
  task run_random(int n_ticks);
    tick_t t;
    repeat (n_ticks) begin
      if (!sb.busy) begin
        t.command_valid = ($urandom_range(0, 9) != 0);
        t.command = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
      end else begin
        t.command_valid = ($urandom_range(0, 7) == 0);
        t.command = 3'($urandom);
      end
      t.write_data = 8'($urandom);
      t.sda_sample = 1'($urandom);
      send_tick(t);
    end
  endtask

  // stop offering and let every result drain before touching the register
  task settle();
    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // pipeline is two deep, give it a few more cycles
    repeat (4) @(posedge clk);
  endtask

  // result side: random stall per transaction, one long hold-off on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the register and one sequence at it
    cfg_read_check();
    run_command(CMD_START, 8'h00, 2, 1'b0);
    settle();

    // every command at one tick per phase, line extremes
    cfg_write(32'd1);
    cfg_read_check();
    run_command(CMD_STOP, 8'h00, 2, 1'b0);
    run_command(CMD_SEND_ACK, 8'hff, 2, 1'b0);
    run_command(CMD_SEND_NACK, 8'h00, 2, 1'b0);
    run_command(CMD_WAIT_ACK, 8'h00, 0, 1'b0);
    run_command(CMD_WAIT_ACK, 8'h00, 1, 1'b0);
    run_command(CMD_WRITE, 8'h00, 2, 1'b0);
    run_command(CMD_WRITE, 8'hff, 2, 1'b0);
    run_command(CMD_WRITE, 8'ha5, 2, 1'b1);
    run_command(CMD_READ, 8'h00, 1, 1'b0);
    run_command(CMD_READ, 8'hff, 0, 1'b0);
    run_command(CMD_READ, 8'h3c, 2, 1'b1);
    // unused code leaves the block idle
    run_command(CMD_UNUSED, 8'h5a, 2, 1'b0);
    run_command(CMD_START, 8'h00, 2, 1'b1);
    settle();

    // zero phase_ticks acts as one tick, upper data bits are dropped
    cfg_write(32'hffff_0000);
    cfg_read_check();
    run_command(CMD_SEND_ACK, 8'h00, 2, 1'b1);
    run_command(CMD_WRITE, 8'($urandom), 2, 1'b0);
    run_command(CMD_READ, 8'h00, 2, 1'b1);
    run_command(CMD_WAIT_ACK, 8'h00, 2, 1'b1);
    settle();

    // random traffic over several phase lengths and idle patterns
    cfg_write(32'd1);
    run_random(55);
    settle();

    // back to back on both sides
    cfg_write(32'd0);
    send_gap_max = 0;
    recv_gap_max = 0;
    run_random(55);
    settle();

    // sender keeps going while the result side holds off, block must backpressure
    cfg_write(32'd2);
    recv_gap_max = IDLE_MAX;
    hold_req = 1'b1;
    run_random(55);
    settle();

    cfg_write(32'd3);
    send_gap_max = IDLE_MAX;
    run_random(55);
    settle();

    cfg_write(32'h5a5a_0001);
    cfg_read_check();
    send_gap_max = 0;
    run_random(55);
    settle();

    // longest phase: a sequence started at the full counter range, no idling
    cfg_write(32'h0000_ffff);
    cfg_read_check();
    send_gap_max = 0;
    recv_gap_max = 0;
    run_random(20);
    tick_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("ran %0d ticks, %0d results checked, phase_ticks 0 to 65535, with backpressure",
             sb.ticks_seen, sb.results_seen);
    $display("sequences: start %0d stop %0d ack %0d nack %0d wait %0d write %0d read %0d",
             sb.started[CMD_START], sb.started[CMD_STOP], sb.started[CMD_SEND_ACK],
             sb.started[CMD_SEND_NACK], sb.started[CMD_WAIT_ACK], sb.started[CMD_WRITE],
             sb.started[CMD_READ]);
    if (sb.errors == 0) begin
      $display("i2c_master_bit_sequencer: match");
    end else begin
      $display("i2c_master_bit_sequencer: mismatch");
    end
    $finish;
  end

endmodule
